>>> sv/sbge_pkg.sv
// Shared types, widths and constants of the spectral band gain equalizer.
// Used by every module of the block; depends on nothing else.
package sbge_pkg;

  // Transform size. It is taken to be a power of two, so that the band
  // width and the spline denominator are powers of two as well.
  localparam int FFT_SIZE   = 1024;
  localparam int HALF       = FFT_SIZE / 2;
  localparam int HALF_LOG2  = $clog2(HALF);
  localparam int BAND_WIDTH = ((FFT_SIZE / 16) < 1) ? 1 : (FFT_SIZE / 16);
  localparam int WL         = $clog2(BAND_WIDTH);

  // Band gain bank.
  localparam int NUM_BANDS  = 8;
  localparam int BAND_IDX_W = $clog2(NUM_BANDS);
  localparam int GAIN_W     = 16;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(8192);

  // Field widths.
  localparam int BIN_W     = 9;
  localparam int MAG_W     = 16;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 4;

  // Square root of bin * HALF, resolved a few result bits per stage.
  localparam int ROOT_W    = (BIN_W + HALF_LOG2 + 1) / 2;
  localparam int XP_W      = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int SQ_STEPS  = 3;
  localparam int SQ_STAGES = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;

  // Spline coefficient and Horner accumulator widths.
  localparam int BW      = GAIN_W + 1;
  localparam int CW      = GAIN_W + 4;
  localparam int M1W     = CW + WL + 1;
  localparam int H1W     = CW + WL + 2;
  localparam int H2W     = H1W + WL + 1;
  localparam int H3W     = H2W + WL + 1;
  localparam int SPL_SH  = 3 * WL + 1;
  localparam int GN_W    = H3W - SPL_SH;
  localparam int PROD_W  = MAG_W + 1 + GN_W;

  // Input request and result payloads.
  typedef struct packed {
    logic [BIN_W-1:0] bin_number;
    logic [MAG_W-1:0] bin_magnitude;
  } in_req_t;

  typedef struct packed {
    logic [BIN_W-1:0]        bin_number_out;
    logic signed [OUT_W-1:0] scaled_magnitude;
  } out_res_t;

  // Working state of the square-root recurrence.
  typedef struct packed {
    logic [XP_W-1:0]   x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_state_t;

  // Spline coefficients of one segment.
  typedef struct packed {
    logic [GAIN_W-1:0]   p1;
    logic signed [BW-1:0] b;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] d;
  } coef_t;

  typedef logic [NUM_BANDS-1:0][GAIN_W-1:0] gain_bank_t;

endpackage

>>> sv/sbge_sqrt_stage.sv
// One stage of the pipelined integer square root: a few result bits per stage.
// Depends on sbge_pkg.
module sbge_sqrt_stage import sbge_pkg::*; #(
  parameter int STEPS = SQ_STEPS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      vld_i,
  input  sq_state_t sq_i,
  input  in_req_t   meta_i,
  output logic      vld_o,
  output sq_state_t sq_o,
  output in_req_t   meta_o
);

  logic      vld_r;
  sq_state_t sq_r;
  sq_state_t sq_nxt;
  in_req_t   meta_r;
  logic [REM_W-1:0] trial;

  // Restoring recurrence: bring in two radicand bits, try the next root bit.
  always_comb begin
    sq_nxt = sq_i;
    trial  = '0;
    for (int s = 0; s < STEPS; s++) begin
      sq_nxt.rem = {sq_nxt.rem[REM_W-3:0], sq_nxt.x[XP_W-1 -: 2]};
      sq_nxt.x   = {sq_nxt.x[XP_W-3:0], 2'b00};
      trial      = {1'b0, sq_nxt.root, 2'b01};
      if (sq_nxt.rem >= trial) begin
        sq_nxt.rem  = sq_nxt.rem - trial;
        sq_nxt.root = {sq_nxt.root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_nxt.root = {sq_nxt.root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    sq_r   <= sq_nxt;
    meta_r <= meta_i;
  end

  assign vld_o  = vld_r;
  assign sq_o   = sq_r;
  assign meta_o = meta_r;

endmodule

>>> sv/sbge_band.sv
// Band selection: clamps the warped index, splits it into band and offset,
// fetches the four neighbour gains and forms the spline coefficients. Uses sbge_pkg.
module sbge_band import sbge_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic [ROOT_W-1:0] root_i,
  input  in_req_t           meta_i,
  input  gain_bank_t        gains_i,
  output logic              vld_o,
  output in_req_t           meta_o,
  output logic [WL-1:0]     r_o,
  output coef_t             coef_o
);

  localparam int EW = ((ROOT_W > HALF_LOG2) ? ROOT_W : HALF_LOG2) + 1;

  logic [EW-1:0]         i_ext;
  logic [HALF_LOG2-1:0]  idx;
  logic [BAND_IDX_W-1:0] k;
  logic [BAND_IDX_W-1:0] km2;
  logic [BAND_IDX_W-1:0] km1;
  logic [BAND_IDX_W-1:0] kp1;
  logic signed [CW-1:0]  g0;
  logic signed [CW-1:0]  g1;
  logic signed [CW-1:0]  g2;
  logic signed [CW-1:0]  g3;
  coef_t                 coef_nxt;

  logic          vld_r;
  in_req_t       meta_r;
  logic [WL-1:0] r_r;
  coef_t         coef_r;

  // Warped index, held below HALF for bins past the upper half.
  always_comb begin
    i_ext = EW'(root_i);
    if (i_ext >= EW'(HALF)) begin
      i_ext = EW'(HALF - 1);
    end
    idx = i_ext[HALF_LOG2-1:0];
    k   = idx[HALF_LOG2-1:WL];
  end

  // Neighbour bands, clamped to the first and last band.
  always_comb begin
    km2 = (k < BAND_IDX_W'(2)) ? '0 : k - BAND_IDX_W'(2);
    km1 = (k == '0) ? '0 : k - BAND_IDX_W'(1);
    kp1 = (k == BAND_IDX_W'(NUM_BANDS - 1)) ? k : k + BAND_IDX_W'(1);
    g0  = $signed(CW'(gains_i[km2]));
    g1  = $signed(CW'(gains_i[km1]));
    g2  = $signed(CW'(gains_i[k]));
    g3  = $signed(CW'(gains_i[kp1]));
  end

  // Catmull-Rom coefficients, scaled by two.
  always_comb begin
    coef_nxt.p1 = gains_i[km1];
    coef_nxt.b  = BW'(g2 - g0);
    coef_nxt.c  = (g0 <<< 1) - (g1 <<< 2) - g1 + (g2 <<< 2) - g3;
    coef_nxt.d  = (g1 <<< 1) + g1 - g0 - (g2 <<< 1) - g2 + g3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= meta_i;
    r_r    <= idx[WL-1:0];
    coef_r <= coef_nxt;
  end

  assign vld_o  = vld_r;
  assign meta_o = meta_r;
  assign r_o    = r_r;
  assign coef_o = coef_r;

endmodule

>>> sv/sbge_spline.sv
// Three-stage Horner evaluation of the spline segment at offset r, one
// multiplier per stage; the gain is the sum floored by 2*W^3. Uses sbge_pkg.
module sbge_spline import sbge_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_i,
  input  in_req_t                meta_i,
  input  logic [WL-1:0]          r_i,
  input  coef_t                  coef_i,
  output logic                   vld_o,
  output in_req_t                meta_o,
  output logic signed [GN_W-1:0] gain_o
);

  logic signed [WL:0]      r_s_in;
  logic signed [WL:0]      r_s1;
  logic signed [WL:0]      r_s2;
  logic signed [M1W-1:0]   m1;
  logic signed [H2W-1:0]   m2;
  logic signed [H3W-1:0]   m3;
  logic signed [H1W-1:0]   h1_nxt;
  logic signed [H2W-1:0]   h2_nxt;
  logic signed [H3W-1:0]   h3_nxt;

  logic                    v1_r, v2_r, v3_r;
  in_req_t                 m1_r, m2_r, m3_r;
  logic [WL-1:0]           r1_r, r2_r;
  logic signed [BW-1:0]    b1_r;
  logic [GAIN_W-1:0]       p1_1_r, p1_2_r;
  logic signed [H1W-1:0]   h1_r;
  logic signed [H2W-1:0]   h2_r;
  logic signed [H3W-1:0]   h3_r;

  // First step: d*r + c*W.
  always_comb begin
    r_s_in = $signed({1'b0, r_i});
    m1     = $signed(coef_i.d) * r_s_in;
    h1_nxt = m1 + $signed({$signed(coef_i.c), {WL{1'b0}}});
  end

  // Second step: h1*r + b*W^2.
  always_comb begin
    r_s1   = $signed({1'b0, r1_r});
    m2     = h1_r * r_s1;
    h2_nxt = m2 + $signed({b1_r, {(2 * WL){1'b0}}});
  end

  // Third step: h2*r + 2*P1*W^3.
  always_comb begin
    r_s2   = $signed({1'b0, r2_r});
    m3     = h2_r * r_s2;
    h3_nxt = m3 + $signed({1'b0, p1_2_r, {SPL_SH{1'b0}}});
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    m1_r   <= meta_i;
    r1_r   <= r_i;
    b1_r   <= coef_i.b;
    p1_1_r <= coef_i.p1;
    h1_r   <= h1_nxt;
    m2_r   <= m1_r;
    r2_r   <= r1_r;
    p1_2_r <= p1_1_r;
    h2_r   <= h2_nxt;
    m3_r   <= m2_r;
    h3_r   <= h3_nxt;
  end

  assign vld_o  = v3_r;
  assign meta_o = m3_r;
  // Arithmetic shift gives the floor of the division by 2*W^3.
  assign gain_o = $signed(h3_r[H3W-1:SPL_SH]);

endmodule

>>> sv/sbge_scale.sv
// Scales the bin magnitude by the interpolated gain and saturates the product
// to signed 32 bits in two register stages. Uses sbge_pkg.
module sbge_scale import sbge_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_i,
  input  in_req_t                meta_i,
  input  logic signed [GN_W-1:0] gain_i,
  output logic                   out_valid,
  output out_res_t               out_res
);

  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic [BIN_W-1:0]          bin_r;
  logic                      pv_r;
  logic [PROD_W-OUT_W:0]     hi_bits;
  out_res_t                  res_nxt;
  out_res_t                  res_r;
  logic                      ov_r;

  assign prod_nxt = $signed({1'b0, meta_i.bin_magnitude}) * gain_i;

  // Saturation: in range when all bits from the sign of the result up agree.
  always_comb begin
    hi_bits = prod_r[PROD_W-1:OUT_W-1];
    res_nxt.bin_number_out = bin_r;
    if ((&hi_bits) || !(|hi_bits)) begin
      res_nxt.scaled_magnitude = prod_r[OUT_W-1:0];
    end else if (prod_r[PROD_W-1]) begin
      res_nxt.scaled_magnitude = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      res_nxt.scaled_magnitude = {1'b0, {(OUT_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      pv_r <= vld_i;
      ov_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    bin_r  <= meta_i.bin_number;
    res_r  <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_res   = res_r;

endmodule

>>> sv/spectral_band_gain_equalizer_top.sv
// Eight-band spectral gain equalizer: warped bin index, Catmull-Rom gain, scaling.
// A request taken at one clock edge has its result strobed on out_valid after the input
// register, the square-root stages, the band stage, the spline stages and the scaler.
// Throughput: one request per clock while busy is low, set by the fully pipelined square
// root, spline multiply chain and scaler. Reset (synchronous, rst_n low) empties the
// pipeline and sets all gains to unity; busy is high during reset and until the ready
// register is set after it. Results cannot be held off by the receiver.
module spectral_band_gain_equalizer_top import sbge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_req_t              in_req,
  output logic                 out_valid,
  output out_res_t             out_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  logic        rdy_r;
  logic        accept;
  gain_bank_t  gain_r;

  logic        in_v_r;
  sq_state_t   in_sq_r;
  sq_state_t   in_sq_nxt;
  in_req_t     in_m_r;

  logic        sq_v [SQ_STAGES+1];
  sq_state_t   sq_s [SQ_STAGES+1];
  in_req_t     sq_m [SQ_STAGES+1];

  logic                   bd_v;
  in_req_t                bd_m;
  logic [WL-1:0]          bd_r;
  coef_t                  bd_coef;
  logic                   sp_v;
  in_req_t                sp_m;
  logic signed [GN_W-1:0] sp_gain;

  // Ready after reset; the pipeline never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= 1'b0;
    end else begin
      rdy_r <= 1'b1;
    end
  end

  assign busy      = ~rdy_r;
  assign cfg_ready = rdy_r;
  assign accept    = start & ~busy;

  // Gain registers; writes to indexes past the last band are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        gain_r[b] <= UNITY_GAIN;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_BANDS))) begin
      gain_r[cfg_index[BAND_IDX_W-1:0]] <= cfg_data;
    end
  end

  // Input stage: radicand bin * HALF, a shift since HALF is a power of two.
  always_comb begin
    in_sq_nxt.x    = XP_W'(in_req.bin_number) << HALF_LOG2;
    in_sq_nxt.rem  = '0;
    in_sq_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_sq_r <= in_sq_nxt;
    in_m_r  <= in_req;
  end

  assign sq_v[0] = in_v_r;
  assign sq_s[0] = in_sq_r;
  assign sq_m[0] = in_m_r;

  // Square-root stages.
  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    localparam int LEFT = ROOT_W - g * SQ_STEPS;
    localparam int N    = (LEFT < SQ_STEPS) ? LEFT : SQ_STEPS;
    sbge_sqrt_stage #(.STEPS(N)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (sq_v[g]),
      .sq_i   (sq_s[g]),
      .meta_i (sq_m[g]),
      .vld_o  (sq_v[g+1]),
      .sq_o   (sq_s[g+1]),
      .meta_o (sq_m[g+1])
    );
  end

  sbge_band u_band (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (sq_v[SQ_STAGES]),
    .root_i  (sq_s[SQ_STAGES].root),
    .meta_i  (sq_m[SQ_STAGES]),
    .gains_i (gain_r),
    .vld_o   (bd_v),
    .meta_o  (bd_m),
    .r_o     (bd_r),
    .coef_o  (bd_coef)
  );

  sbge_spline u_spline (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (bd_v),
    .meta_i (bd_m),
    .r_i    (bd_r),
    .coef_i (bd_coef),
    .vld_o  (sp_v),
    .meta_o (sp_m),
    .gain_o (sp_gain)
  );

  sbge_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (sp_v),
    .meta_i    (sp_m),
    .gain_i    (sp_gain),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Every accepted request produces a result strobe on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##10 out_valid)
    else $error("result strobe missing after accepted request");

  // The bin position travels with its own request through all stages.
  a_bin_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##10 (out_res.bin_number_out == $past(in_req.bin_number, 10)))
    else $error("bin position does not match its request");

  // A write to the first band register is registered into gain_r[0].
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == '0)) |=> (gain_r[0] == $past(cfg_data)))
    else $error("band gain register write lost");

endmodule
